@@ sv/epws_pkg.sv @@
// shared types, constants and helpers for the e-paper pixel waveform sweep
// no dependencies; imported by every module of the block
package epws_pkg;

  // waveform table geometry: address is {phase[5:0], next, previous}
  localparam int TABLE_AW    = 16;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;

  // queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // configuration port geometry (64-bit registers at 8-byte spacing)
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  localparam logic [7:0] IDLE_PHASE = 8'hFF;
  localparam logic [2:0] DRIVE_MASK = 3'h7;

  // input action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_SPAN  = 2'd0,
    REG_DC_CAP      = 2'd1,
    REG_DC_ZERO     = 2'd2,
    REG_PULSE_BYTES = 2'd3
  } epws_reg_t;

  // item class decided by the front
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_IDLE   = 2'd1,
    KIND_ACTIVE = 2'd2
  } epws_kind_t;

  typedef struct packed {
    logic [6:0]  frame_span;
    logic [6:0]  dc_cap;
    logic        dc_zero_at_end;
    logic [63:0] pulse_bytes;
  } epws_cfg_t;

  typedef struct packed {
    epws_kind_t         kind;
    logic [11:0]        pixel_x;
    logic [7:0]         frame_index;
    logic [4:0]         prev_level;
    logic [4:0]         next_level;
    logic [4:0]         final_level;
    logic signed [7:0]  dc_balance;
    logic               prev_estimated;
    logic               segment_start;
  } epws_item_t;

  typedef struct packed {
    epws_item_t  item;
    logic [7:0]  code;
  } epws_entry_t;

  typedef struct packed {
    logic               op_valid;
    logic [11:0]        op_x;
    logic [7:0]         op_code;
    logic [7:0]         new_frame_index;
    logic [4:0]         new_prev_level;
    logic [4:0]         new_next_level;
    logic signed [7:0]  new_dc;
    logic               new_prev_estimated;
    logic signed [31:0] impulse_total;
    logic [15:0]        saturation_count;
    logic [15:0]        completed_count;
    logic               any_drove;
  } epws_result_t;

  // 16-bit counter that sticks at its maximum
  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

@@ sv/epws_front.sv @@
// front: accepts items, classifies them and owns the waveform table memory
// depends on epws_pkg; feeds epws_fifo
module epws_front
  import epws_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              action,
  input  logic [15:0]       table_index,
  input  logic [7:0]        table_code,
  input  logic [11:0]       pixel_x,
  input  logic [7:0]        frame_index,
  input  logic [4:0]        prev_level,
  input  logic [4:0]        next_level,
  input  logic [4:0]        final_level,
  input  logic signed [7:0] dc_balance,
  input  logic              prev_estimated,
  input  logic              segment_start,
  input  logic              q_full,
  output logic              push,
  output epws_entry_t       push_entry
);

  logic [7:0]          wave_mem [TABLE_DEPTH];
  logic [7:0]          rd_code;
  logic [TABLE_AW-1:0] rd_addr;
  logic                accept;
  logic                s1_valid;
  epws_item_t          s1_item;
  epws_item_t          item_in;

  // the lookup stage holds while the queue is full
  assign in_stall = s1_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = s1_valid && !q_full;

  // table address, phase wraps above 63
  assign rd_addr = {frame_index[5:0], next_level, prev_level};

  // classify the incoming item
  always_comb begin
    item_in.pixel_x        = pixel_x;
    item_in.frame_index    = frame_index;
    item_in.prev_level     = prev_level;
    item_in.next_level     = next_level;
    item_in.final_level    = final_level;
    item_in.dc_balance     = dc_balance;
    item_in.prev_estimated = prev_estimated;
    item_in.segment_start  = segment_start;
    if (action == ACT_LOAD) begin
      item_in.kind = KIND_LOAD;
    end else if (frame_index == IDLE_PHASE) begin
      item_in.kind = KIND_IDLE;
    end else begin
      item_in.kind = KIND_ACTIVE;
    end
  end

  // table write on load, registered read on a pixel
  // rd_code only moves on accept, so it holds while the stage stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      if (action == ACT_LOAD) begin
        wave_mem[table_index] <= table_code;
      end else begin
        rd_code <= wave_mem[rd_addr];
      end
    end
  end

  // lookup stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  // lookup stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item_in;
    end
  end

  assign push_entry.item = s1_item;
  assign push_entry.code = rd_code;

endmodule

@@ sv/epws_fifo.sv @@
// small queue decoupling the front from the back
// depends on epws_pkg for the entry type
module epws_fifo
  import epws_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  epws_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output logic        not_empty,
  output epws_entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  epws_entry_t   slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // no overrun or underrun, count tracks a lone push
  a_no_overrun: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

@@ sv/epws_back.sv @@
// back: applies drive code, dc ledger, phase advance and segment totals
// depends on epws_pkg; reads from epws_fifo and drives the result register
module epws_back
  import epws_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  epws_cfg_t    cfg,
  input  logic         q_not_empty,
  input  epws_entry_t  q_head,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output epws_result_t res
);

  logic signed [31:0] impulse_sum;
  logic [15:0]        clamp_count;
  logic [15:0]        done_count;
  logic               drove_flag;

  logic signed [31:0] impulse_sum_next;
  logic [15:0]        clamp_count_next;
  logic [15:0]        done_count_next;
  logic               drove_flag_next;
  epws_result_t       res_next;

  epws_item_t         it;
  logic [2:0]         low;
  logic signed [7:0]  imp;
  logic signed [8:0]  dc_sum;
  logic signed [8:0]  cap9;
  logic signed [7:0]  dc_charged;
  logic               clamped;
  logic [7:0]         phase_inc;
  logic               wave_end;
  logic               retarget;
  logic signed [7:0]  dc_final;
  logic signed [31:0] sum_base;
  logic [15:0]        clamp_base;
  logic [15:0]        done_base;
  logic               drove_base;

  // take the queue head when the result register is free or draining
  assign q_pop = q_not_empty && (!out_valid || !out_stall);
  assign it    = q_head.item;

  // impulse select and dc charge with symmetric clamp
  always_comb begin
    low        = q_head.code[2:0] & DRIVE_MASK;
    imp        = signed'(cfg.pulse_bytes[{low, 3'b000} +: 8]);
    dc_sum     = 9'(it.dc_balance) + 9'(imp);
    cap9       = signed'({2'b00, cfg.dc_cap});
    clamped    = 1'b0;
    dc_charged = it.dc_balance;
    if (imp != 8'sd0) begin
      if (dc_sum > cap9) begin
        dc_charged = cap9[7:0];
        clamped    = 1'b1;
      end else if (dc_sum < -cap9) begin
        dc_charged = 8'(-cap9);
        clamped    = 1'b1;
      end else begin
        dc_charged = dc_sum[7:0];
      end
    end
  end

  // phase advance and waveform end
  always_comb begin
    phase_inc = it.frame_index + 8'd1;
    wave_end  = (phase_inc >= {1'b0, cfg.frame_span});
    retarget  = (it.final_level != it.next_level);
    dc_final  = (wave_end && cfg.dc_zero_at_end) ? 8'sd0 : dc_charged;
  end

  // segment totals, cleared ahead of a pixel that opens a segment
  always_comb begin
    if (it.kind != KIND_LOAD && it.segment_start) begin
      sum_base   = '0;
      clamp_base = '0;
      done_base  = '0;
      drove_base = 1'b0;
    end else begin
      sum_base   = impulse_sum;
      clamp_base = clamp_count;
      done_base  = done_count;
      drove_base = drove_flag;
    end
  end

  // result and next totals per item class
  always_comb begin
    impulse_sum_next = sum_base;
    clamp_count_next = clamp_base;
    done_count_next  = done_base;
    drove_flag_next  = drove_base;
    res_next         = '0;
    unique case (it.kind)
      KIND_LOAD: begin
      end
      KIND_IDLE: begin
        res_next.new_frame_index    = it.frame_index;
        res_next.new_prev_level     = it.prev_level;
        res_next.new_next_level     = it.next_level;
        res_next.new_dc             = it.dc_balance;
        res_next.new_prev_estimated = it.prev_estimated;
      end
      KIND_ACTIVE: begin
        if (low != 3'd0) begin
          impulse_sum_next = sum_base + 32'(imp);
          drove_flag_next  = 1'b1;
        end
        if (clamped) begin
          clamp_count_next = sat_inc16(clamp_base);
        end
        res_next.op_valid           = 1'b1;
        res_next.op_x               = it.pixel_x;
        res_next.op_code            = q_head.code;
        res_next.new_dc             = dc_final;
        res_next.new_frame_index    = phase_inc;
        res_next.new_prev_level     = it.prev_level;
        res_next.new_next_level     = it.next_level;
        res_next.new_prev_estimated = it.prev_estimated;
        if (wave_end) begin
          res_next.new_prev_level     = it.next_level;
          res_next.new_prev_estimated = 1'b0;
          if (retarget) begin
            res_next.new_next_level  = it.final_level;
            res_next.new_frame_index = 8'd0;
          end else begin
            res_next.new_frame_index = IDLE_PHASE;
            done_count_next          = sat_inc16(done_base);
          end
        end
      end
      default: begin
      end
    endcase
    res_next.impulse_total    = impulse_sum_next;
    res_next.saturation_count = clamp_count_next;
    res_next.completed_count  = done_count_next;
    res_next.any_drove        = drove_flag_next;
  end

  // totals and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      impulse_sum <= '0;
      clamp_count <= '0;
      done_count  <= '0;
      drove_flag  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        impulse_sum <= impulse_sum_next;
        clamp_count <= clamp_count_next;
        done_count  <= done_count_next;
        drove_flag  <= drove_flag_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= res_next;
    end
  end

  // an op leaves a pixel in a valid phase, no op means empty op fields,
  // a driving code always shows in the segment flag
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.op_valid) |->
      (res.new_frame_index < 8'd128 || res.new_frame_index == IDLE_PHASE))
    else $error("active pixel left in an impossible phase");
  a_no_op_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.op_valid) |-> (res.op_code == 8'd0 && res.op_x == 12'd0))
    else $error("op fields set without an op");
  a_drive_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.op_valid && res.op_code[2:0] != 3'd0) |-> res.any_drove)
    else $error("driving op not reflected in segment flag");

endmodule

@@ sv/epaper_pixel_waveform_sweep_top.sv @@
// top level of the e-paper pixel waveform sweep: config registers and wiring
// depends on epws_pkg, epws_front, epws_fifo and epws_back
//
// One item is taken per clock cycle while in_stall is low; the single-port
// waveform table (65536 x 8, one access per item, written by load items and
// read by pixels) sets that figure. An accepted item passes the table read
// into the lookup stage in the front, then a queue slot, after which the back
// registers the result. A queue of QUEUE_DEPTH entries lets the front keep
// accepting while the result side is stalled; in_stall rises once the queue
// and the lookup stage are full. The table comes up unwritten and needs no
// clearing pass; a pixel must only reach entries already loaded.
// Registers sit at byte addresses 0 (frames per waveform), 8 (dc cap),
// 16 (dc zeroing at waveform end) and 24 (eight signed impulse bytes) and may
// only be written while idle.
module epaper_pixel_waveform_sweep_top
  import epws_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [15:0]        table_index,
  input  logic [7:0]         table_code,
  input  logic [11:0]        pixel_x,
  input  logic [7:0]         frame_index,
  input  logic [4:0]         prev_level,
  input  logic [4:0]         next_level,
  input  logic [4:0]         final_level,
  input  logic signed [7:0]  dc_balance,
  input  logic               prev_estimated,
  input  logic               segment_start,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               op_valid,
  output logic [11:0]        op_x,
  output logic [7:0]         op_code,
  output logic [7:0]         new_frame_index,
  output logic [4:0]         new_prev_level,
  output logic [4:0]         new_next_level,
  output logic signed [7:0]  new_dc,
  output logic               new_prev_estimated,
  output logic signed [31:0] impulse_total,
  output logic [15:0]        saturation_count,
  output logic [15:0]        completed_count,
  output logic               any_drove
);

  epws_cfg_t    cfg;
  epws_reg_t    reg_sel;
  logic         cfg_write;
  logic         q_full;
  logic         q_not_empty;
  logic         q_push;
  logic         q_pop;
  epws_entry_t  push_entry;
  epws_entry_t  q_head;
  epws_result_t res;

  assign pready    = 1'b1;
  assign reg_sel   = epws_reg_t'(paddr[CFG_AW-1:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_span     <= 7'd1;
      cfg.dc_cap         <= 7'd127;
      cfg.dc_zero_at_end <= 1'b0;
      cfg.pulse_bytes    <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_FRAME_SPAN:  cfg.frame_span     <= pwdata[6:0];
        REG_DC_CAP:      cfg.dc_cap         <= pwdata[6:0];
        REG_DC_ZERO:     cfg.dc_zero_at_end <= pwdata[0];
        REG_PULSE_BYTES: cfg.pulse_bytes    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_sel)
      REG_FRAME_SPAN:  prdata = CFG_DW'(cfg.frame_span);
      REG_DC_CAP:      prdata = CFG_DW'(cfg.dc_cap);
      REG_DC_ZERO:     prdata = CFG_DW'(cfg.dc_zero_at_end);
      REG_PULSE_BYTES: prdata = cfg.pulse_bytes;
      default:         prdata = '0;
    endcase
  end

  epws_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .table_index    (table_index),
    .table_code     (table_code),
    .pixel_x        (pixel_x),
    .frame_index    (frame_index),
    .prev_level     (prev_level),
    .next_level     (next_level),
    .final_level    (final_level),
    .dc_balance     (dc_balance),
    .prev_estimated (prev_estimated),
    .segment_start  (segment_start),
    .q_full         (q_full),
    .push           (q_push),
    .push_entry     (push_entry)
  );

  epws_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  epws_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res)
  );

  // result fields
  assign op_valid           = res.op_valid;
  assign op_x               = res.op_x;
  assign op_code            = res.op_code;
  assign new_frame_index    = res.new_frame_index;
  assign new_prev_level     = res.new_prev_level;
  assign new_next_level     = res.new_next_level;
  assign new_dc             = res.new_dc;
  assign new_prev_estimated = res.new_prev_estimated;
  assign impulse_total      = res.impulse_total;
  assign saturation_count   = res.saturation_count;
  assign completed_count    = res.completed_count;
  assign any_drove          = res.any_drove;

endmodule

@@ bench/epaper_pixel_waveform_sweep_top_tb.sv @@
// self-checking bench for the e-paper pixel waveform sweep: a directed table
// followed by random pixel sweeps, each result checked against an in-bench model
// depends on epws_pkg and epaper_pixel_waveform_sweep_top
module epaper_pixel_waveform_sweep_top_tb;
  import epws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SIZE = 8;
  localparam int N_SETTINGS = 8;
  localparam int STEPS_PER_SETTING = 75;
  localparam logic [63:0] DRILL_MAP = 64'h00_FB_05_FF_01_80_7F_00;

  // one input item as the bench sees it
  typedef struct packed {
    logic              action;
    logic [15:0]       table_index;
    logic [7:0]        table_code;
    logic [11:0]       pixel_x;
    logic [7:0]        frame_index;
    logic [4:0]        prev_level;
    logic [4:0]        next_level;
    logic [4:0]        final_level;
    logic signed [7:0] dc_balance;
    logic              prev_estimated;
    logic              segment_start;
  } sweep_item_t;

  localparam int ITEM_W = $bits(sweep_item_t);

  // a pixel carried from frame to frame by the random sweeps
  typedef struct {
    logic [11:0]       x;
    logic [7:0]        phase;
    logic [4:0]        prv;
    logic [4:0]        nxt;
    logic signed [7:0] dc;
    logic              est;
  } pixel_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [CFG_DW-1:0]  pwdata = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               action = 1'b0;
  logic [15:0]        table_index = '0;
  logic [7:0]         table_code = '0;
  logic [11:0]        pixel_x = '0;
  logic [7:0]         frame_index = '0;
  logic [4:0]         prev_level = '0;
  logic [4:0]         next_level = '0;
  logic [4:0]         final_level = '0;
  logic signed [7:0]  dc_balance = '0;
  logic               prev_estimated = 1'b0;
  logic               segment_start = 1'b0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               op_valid;
  logic [11:0]        op_x;
  logic [7:0]         op_code;
  logic [7:0]         new_frame_index;
  logic [4:0]         new_prev_level;
  logic [4:0]         new_next_level;
  logic signed [7:0]  new_dc;
  logic               new_prev_estimated;
  logic signed [31:0] impulse_total;
  logic [15:0]        saturation_count;
  logic [15:0]        completed_count;
  logic               any_drove;

  // model state: waveform table, segment totals and register copies
  logic [7:0]  wave_lut [0:TABLE_DEPTH-1];
  bit          lut_loaded [0:TABLE_DEPTH-1];
  logic [31:0] acc_impulse = '0;
  logic [15:0] acc_clamps = '0;
  logic [15:0] acc_done = '0;
  logic        acc_drove = 1'b0;
  logic [6:0]  cfg_frame_span = 7'd1;
  logic [6:0]  cfg_dc_cap = 7'd127;
  logic        cfg_renorm = 1'b0;
  logic [63:0] cfg_pulse_bytes = '0;

  epws_result_t pending_results [$];
  pixel_state_t pool [POOL_SIZE];
  bit send_calm = 1'b0;
  int mismatches = 0;
  int n_loads = 0, n_active = 0, n_idle = 0, n_ends = 0, n_clamps = 0, n_settings = 0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  epaper_pixel_waveform_sweep_top dut (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .action             (action),
    .table_index        (table_index),
    .table_code         (table_code),
    .pixel_x            (pixel_x),
    .frame_index        (frame_index),
    .prev_level         (prev_level),
    .next_level         (next_level),
    .final_level        (final_level),
    .dc_balance         (dc_balance),
    .prev_estimated     (prev_estimated),
    .segment_start      (segment_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .op_valid           (op_valid),
    .op_x               (op_x),
    .op_code            (op_code),
    .new_frame_index    (new_frame_index),
    .new_prev_level     (new_prev_level),
    .new_next_level     (new_next_level),
    .new_dc             (new_dc),
    .new_prev_estimated (new_prev_estimated),
    .impulse_total      (impulse_total),
    .saturation_count   (saturation_count),
    .completed_count    (completed_count),
    .any_drove          (any_drove)
  );

  // table address: low six phase bits, then next level, then previous level
  function automatic logic [15:0] lut_addr(input logic [7:0] f, input logic [4:0] nxt,
                                           input logic [4:0] prv);
    return {f[5:0], nxt, prv};
  endfunction

  // expected result of one item; updates the table and the segment totals
  function automatic epws_result_t predict_sweep(input sweep_item_t it);
    epws_result_t r;
    logic [7:0] code, ph;
    logic [4:0] prv, nxt;
    logic [2:0] drive;
    logic signed [7:0] imp;
    logic est, clamped;
    int dcv, sum, cap;
    r = '0;
    if (it.action == ACT_LOAD) begin
      wave_lut[it.table_index] = it.table_code;
      lut_loaded[it.table_index] = 1'b1;
      n_loads++;
    end else begin
      if (it.segment_start) begin
        acc_impulse = '0;
        acc_clamps = '0;
        acc_done = '0;
        acc_drove = 1'b0;
      end
      r.new_frame_index = it.frame_index;
      r.new_prev_level = it.prev_level;
      r.new_next_level = it.next_level;
      r.new_dc = it.dc_balance;
      r.new_prev_estimated = it.prev_estimated;
      if (it.frame_index == IDLE_PHASE) begin
        n_idle++;
      end else begin
        n_active++;
        code = wave_lut[lut_addr(it.frame_index, it.next_level, it.prev_level)];
        drive = code[2:0] & DRIVE_MASK;
        imp = cfg_pulse_bytes[8*drive +: 8];
        dcv = $signed(it.dc_balance);
        if (drive != 3'd0) begin
          acc_impulse = acc_impulse + {{24{imp[7]}}, imp};
          acc_drove = 1'b1;
        end
        // charge the dc ledger and clamp to the symmetric cap
        clamped = 1'b0;
        if (imp != 8'sd0) begin
          sum = dcv + int'(imp);
          cap = int'({1'b0, cfg_dc_cap});
          if (sum > cap) begin
            dcv = cap;
            clamped = 1'b1;
          end else if (sum < -cap) begin
            dcv = -cap;
            clamped = 1'b1;
          end else begin
            dcv = sum;
          end
        end
        if (clamped) begin
          n_clamps++;
          if (acc_clamps != 16'hFFFF) acc_clamps = acc_clamps + 16'd1;
        end
        // advance the phase; at the waveform end promote, then retarget or go idle
        ph = it.frame_index + 8'd1;
        prv = it.prev_level;
        nxt = it.next_level;
        est = it.prev_estimated;
        if (ph >= {1'b0, cfg_frame_span}) begin
          n_ends++;
          prv = nxt;
          est = 1'b0;
          if (cfg_renorm) dcv = 0;
          if (it.final_level != nxt) begin
            nxt = it.final_level;
            ph = 8'd0;
          end else begin
            ph = IDLE_PHASE;
            if (acc_done != 16'hFFFF) acc_done = acc_done + 16'd1;
          end
        end
        r.op_valid = 1'b1;
        r.op_x = it.pixel_x;
        r.op_code = code;
        r.new_frame_index = ph;
        r.new_prev_level = prv;
        r.new_next_level = nxt;
        r.new_dc = dcv[7:0];
        r.new_prev_estimated = est;
      end
    end
    r.impulse_total = acc_impulse;
    r.saturation_count = acc_clamps;
    r.completed_count = acc_done;
    r.any_drove = acc_drove;
    return r;
  endfunction

  function automatic sweep_item_t load_item(input logic [15:0] idx, input logic [7:0] code,
                                            input logic seg);
    sweep_item_t it;
    it = '0;
    it.action = ACT_LOAD;
    it.table_index = idx;
    it.table_code = code;
    it.segment_start = seg;
    return it;
  endfunction

  function automatic sweep_item_t pixel_item(input logic [11:0] x, input logic [7:0] f,
                                             input logic [4:0] prv, input logic [4:0] nxt,
                                             input logic [4:0] fin, input logic [7:0] dc,
                                             input logic est, input logic seg);
    sweep_item_t it;
    it = '0;
    it.action = ACT_PIXEL;
    it.pixel_x = x;
    it.frame_index = f;
    it.prev_level = prv;
    it.next_level = nxt;
    it.final_level = fin;
    it.dc_balance = dc;
    it.prev_estimated = est;
    it.segment_start = seg;
    return it;
  endfunction

  function automatic sweep_item_t random_item();
    return sweep_item_t'(ITEM_W'({$urandom(), $urandom(), $urandom()}));
  endfunction

  // register write: setup cycle, then access cycle until pready
  task automatic cfg_write(input epws_reg_t r, input logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 3'b000};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_FRAME_SPAN:  cfg_frame_span = v[6:0];
      REG_DC_CAP:      cfg_dc_cap = v[6:0];
      REG_DC_ZERO:     cfg_renorm = v[0];
      REG_PULSE_BYTES: cfg_pulse_bytes = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [6:0] pc, input logic [6:0] cap, input logic renorm,
                               input logic [63:0] imap);
    cfg_write(REG_FRAME_SPAN, {57'd0, pc});
    cfg_write(REG_DC_CAP, {57'd0, cap});
    cfg_write(REG_DC_ZERO, {63'd0, renorm});
    cfg_write(REG_PULSE_BYTES, imap);
    n_settings++;
  endtask

  // hold the input side until every result is back, then let the pipe settle
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // offer one item after a random gap; predict it once accepted
  task automatic send_item(input sweep_item_t it, input bit typed, input epws_result_t typed_res,
                           output epws_result_t res);
    int gap;
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= it.action;
    table_index <= it.table_index;
    table_code <= it.table_code;
    pixel_x <= it.pixel_x;
    frame_index <= it.frame_index;
    prev_level <= it.prev_level;
    next_level <= it.next_level;
    final_level <= it.final_level;
    dc_balance <= it.dc_balance;
    prev_estimated <= it.prev_estimated;
    segment_start <= it.segment_start;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = predict_sweep(it);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // one random step: stray load, arbitrary pixel, or the next frame of a pooled pixel
  task automatic random_step();
    sweep_item_t it;
    epws_result_t res;
    int k, pick;
    logic [4:0] fin;
    logic [15:0] addr;
    pick = $urandom_range(0, 99);
    k = -1;
    if (pick < 10) begin
      it = random_item();
      it.action = ACT_LOAD;
    end else if (pick < 25) begin
      it = random_item();
      it.action = ACT_PIXEL;
    end else begin
      k = $urandom_range(0, POOL_SIZE - 1);
      if (pool[k].phase == IDLE_PHASE && $urandom_range(0, 1) == 1) begin
        pool[k].phase = 8'd0;
        pool[k].nxt = 5'($urandom_range(0, 31));
        pool[k].est = 1'($urandom_range(0, 1));
      end
      fin = ($urandom_range(0, 9) < 6) ? pool[k].nxt : 5'($urandom_range(0, 31));
      it = pixel_item(pool[k].x, pool[k].phase, pool[k].prv, pool[k].nxt, fin, pool[k].dc,
                      pool[k].est, $urandom_range(0, 19) == 0);
    end
    // an active pixel may only read a loaded table entry
    if (it.action == ACT_PIXEL && it.frame_index != IDLE_PHASE) begin
      addr = lut_addr(it.frame_index, it.next_level, it.prev_level);
      if (!lut_loaded[addr])
        send_item(load_item(addr, 8'($urandom()), 1'($urandom_range(0, 1))), 1'b0, '0, res);
    end
    send_item(it, 1'b0, '0, res);
    if (k >= 0) begin
      pool[k].phase = res.new_frame_index;
      pool[k].prv = res.new_prev_level;
      pool[k].nxt = res.new_next_level;
      pool[k].dc = res.new_dc;
      pool[k].est = res.new_prev_estimated;
    end
  endtask

  // result side: random stall before each item, with calm stretches
  initial begin : result_sink
    int hold;
    bit calm;
    calm = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] seen);
    if (seen !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
    end
  endtask

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    epws_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no item outstanding", $time);
      end else begin
        want = pending_results.pop_front();
        check_field("op_valid", 32'(want.op_valid), 32'(op_valid));
        check_field("op_x", 32'(want.op_x), 32'(op_x));
        check_field("op_code", 32'(want.op_code), 32'(op_code));
        check_field("new_frame_index", 32'(want.new_frame_index), 32'(new_frame_index));
        check_field("new_prev_level", 32'(want.new_prev_level), 32'(new_prev_level));
        check_field("new_next_level", 32'(want.new_next_level), 32'(new_next_level));
        check_field("new_dc", 32'(want.new_dc), 32'(new_dc));
        check_field("new_prev_estimated", 32'(want.new_prev_estimated),
                    32'(new_prev_estimated));
        check_field("impulse_total", want.impulse_total, impulse_total);
        check_field("saturation_count", 32'(want.saturation_count), 32'(saturation_count));
        check_field("completed_count", 32'(want.completed_count), 32'(completed_count));
        check_field("any_drove", 32'(want.any_drove), 32'(any_drove));
      end
    end
  end

  // main sequence: reset, directed table, then random settings
  initial begin : stimulus
    sweep_item_t drill_items [$];
    bit drill_typed [$];
    epws_result_t drill_want [$];
    epws_result_t idle_want, res;
    int i, s;
    for (i = 0; i < POOL_SIZE; i++) begin
      pool[i].x = 12'($urandom());
      pool[i].phase = IDLE_PHASE;
      pool[i].prv = 5'($urandom_range(0, 31));
      pool[i].nxt = pool[i].prv;
      pool[i].dc = '0;
      pool[i].est = 1'($urandom_range(0, 1));
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part: two-frame waveform, cap 100, mixed impulses
    apply_setting(7'd2, 7'd100, 1'b0, DRILL_MAP);
    idle_want = '0;
    idle_want.new_frame_index = IDLE_PHASE;
    idle_want.new_prev_level = 5'd31;
    idle_want.new_next_level = 5'd0;
    idle_want.new_dc = -8'sd128;
    idle_want.new_prev_estimated = 1'b1;
    // loads at the table corners and for each case below
    drill_items.push_back(load_item(16'h0000, 8'h01, 1'b0));
    drill_items.push_back(load_item(16'hFFFF, 8'hFA, 1'b0));
    drill_items.push_back(load_item(16'hF800, 8'h04, 1'b0));
    drill_items.push_back(load_item(16'h0021, 8'h08, 1'b0));
    drill_items.push_back(load_item(16'h0442, 8'hFF, 1'b0));
    drill_items.push_back(load_item(16'h0463, 8'h03, 1'b0));
    // idle pixel at the field extremes, passed straight through
    drill_items.push_back(pixel_item(12'hFFF, IDLE_PHASE, 5'd31, 5'd0, 5'd5, 8'h80, 1'b1, 1'b1));
    for (i = 0; i < drill_items.size(); i++) begin
      drill_typed.push_back(1'b1);
      drill_want.push_back(i == drill_items.size() - 1 ? idle_want : epws_result_t'('0));
    end
    // positive clamp, no waveform end
    drill_items.push_back(pixel_item(12'h000, 8'd0, 5'd0, 5'd0, 5'd0, 8'd0, 1'b1, 1'b0));
    // negative clamp at the top address, pixel completes
    drill_items.push_back(pixel_item(12'hFFF, 8'd63, 5'd31, 5'd31, 5'd31, 8'h80, 1'b1, 1'b0));
    // phase above 63 wraps onto the same entry, then retargets
    drill_items.push_back(pixel_item(12'h5A5, 8'd127, 5'd31, 5'd31, 5'd0, 8'h7F, 1'b0, 1'b0));
    // last active phase
    drill_items.push_back(pixel_item(12'hA5A, 8'd254, 5'd0, 5'd0, 5'd7, 8'd0, 1'b1, 1'b0));
    // code with no drive bits
    drill_items.push_back(pixel_item(12'h001, 8'd0, 5'd1, 5'd1, 5'd1, 8'd50, 1'b0, 1'b0));
    // drive bits whose impulse is zero
    drill_items.push_back(pixel_item(12'h002, 8'd1, 5'd2, 5'd2, 5'd2, 8'd50, 1'b1, 1'b0));
    // charge landing exactly on the cap
    drill_items.push_back(pixel_item(12'h003, 8'd1, 5'd3, 5'd3, 5'd9, 8'd99, 1'b0, 1'b0));
    // segment start on a load is ignored
    drill_items.push_back(load_item(16'h1234, 8'h55, 1'b1));
    // segment start on a pixel clears the totals
    drill_items.push_back(pixel_item(12'h7FF, 8'd1, 5'd3, 5'd3, 5'd3, 8'd100, 1'b1, 1'b1));
    drill_items.push_back(pixel_item(12'h800, IDLE_PHASE, 5'd0, 5'd31, 5'd31, 8'h7F, 1'b0,
                                     1'b0));
    while (drill_typed.size() < drill_items.size()) begin
      drill_typed.push_back(1'b0);
      drill_want.push_back('0);
    end
    for (i = 0; i < drill_items.size(); i++)
      send_item(drill_items[i], drill_typed[i], drill_want[i], res);

    // random part under a series of register settings
    for (s = 0; s < N_SETTINGS; s++) begin
      wait_idle(4);
      case (s)
        0: apply_setting(7'd1, 7'd127, 1'b0, {$urandom(), $urandom()});
        1: apply_setting(7'd64, 7'd0, 1'b1, 64'h8080_8080_8080_8080);
        2: apply_setting(7'd0, 7'd127, 1'b0, 64'h7F7F_7F7F_7F7F_7F7F);
        3: apply_setting(7'd127, 7'd5, 1'b1, {$urandom(), $urandom()});
        4: apply_setting(7'd3, 7'd127, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        5: apply_setting(7'd2, 7'($urandom()), 1'($urandom()), 64'h0);
        default: apply_setting(7'($urandom_range(1, 8)), 7'($urandom()), 1'($urandom()),
                               {$urandom(), $urandom()});
      endcase
      repeat (STEPS_PER_SETTING) random_step();
    end

    wait_idle(10);
    $display("covered %0d loads, %0d active and %0d idle pixels over %0d register settings",
             n_loads, n_active, n_idle, n_settings);
    $display("%0d waveform ends, %0d dc clamps, %0d field mismatches",
             n_ends, n_clamps, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin : watchdog
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
sv/epws_pkg.sv
sv/epws_front.sv
sv/epws_fifo.sv
sv/epws_back.sv
sv/epaper_pixel_waveform_sweep_top.sv
bench/epaper_pixel_waveform_sweep_top_tb.sv
